// ===== rtl/core/mep_pkg.sv =====
// ----------------------------------------------------------------------------
// mep_pkg - shared types and constants for the Mandelbrot escape-time pixel
// Fixed-point formats, register indexes, saturation helpers and the palette.
// ----------------------------------------------------------------------------
`default_nettype none

package mep_pkg;

  // Word format: two's complement, Q8.24
  localparam int WORD_BITS = 32;
  localparam int FRAC_BITS = 24;

  // Register field widths
  localparam int STEP_BITS   = WORD_BITS - 1;
  localparam int ITER_BITS   = 8;
  localparam int COUNT_BITS  = ITER_BITS + 1;
  localparam int OFFS_BITS   = 4;
  localparam int PIX_BITS    = 8;
  localparam int CFG_IDX_BITS = 3;
  localparam int CFG_DATA_BITS = WORD_BITS;
  localparam int COLOR_BITS  = 8;

  // Stream payload widths
  localparam int S_DATA_BITS = 2 * PIX_BITS;
  localparam int M_DATA_RAW  = COUNT_BITS + 3 * COLOR_BITS;
  localparam int M_DATA_BITS = ((M_DATA_RAW + 7) / 8) * 8;

  // Iteration datapath: operands stay within +-2.0 once they get to a multiplier
  localparam int MAG_BITS  = FRAC_BITS + 3;
  localparam int PROD_BITS = 2 * MAG_BITS;
  localparam int TERM_BITS = FRAC_BITS + 5;
  localparam int SUM_BITS  = WORD_BITS + 2;

  // Coordinate forming: word plus pixel index times step
  localparam int OFF_BITS  = PIX_BITS + STEP_BITS;
  localparam int CSUM_BITS = OFF_BITS + 3;

  localparam logic signed [WORD_BITS-1:0] WORD_MAX = {1'b0, {(WORD_BITS-1){1'b1}}};
  localparam logic signed [WORD_BITS-1:0] WORD_MIN = {1'b1, {(WORD_BITS-1){1'b0}}};
  localparam logic signed [SUM_BITS-1:0]  SUM_MAX  = SUM_BITS'(WORD_MAX);
  localparam logic signed [SUM_BITS-1:0]  SUM_MIN  = SUM_BITS'(WORD_MIN);
  localparam logic signed [CSUM_BITS-1:0] CSUM_MAX = CSUM_BITS'(WORD_MAX);
  localparam logic signed [CSUM_BITS-1:0] CSUM_MIN = CSUM_BITS'(WORD_MIN);

  localparam logic signed [WORD_BITS-1:0] BOUND_POS =
    WORD_BITS'(longint'(1) << (FRAC_BITS + 1));
  localparam logic signed [WORD_BITS-1:0] BOUND_NEG = -BOUND_POS;
  localparam logic signed [TERM_BITS-1:0] FOUR_TERM =
    TERM_BITS'(longint'(1) << (FRAC_BITS + 2));

  // Register indexes on the configuration channel
  localparam logic [CFG_IDX_BITS-1:0] REG_LEFT_REAL    = 3'd0;
  localparam logic [CFG_IDX_BITS-1:0] REG_TOP_IMAG     = 3'd1;
  localparam logic [CFG_IDX_BITS-1:0] REG_STEP_REAL    = 3'd2;
  localparam logic [CFG_IDX_BITS-1:0] REG_STEP_IMAG    = 3'd3;
  localparam logic [CFG_IDX_BITS-1:0] REG_MAX_ITER     = 3'd4;
  localparam logic [CFG_IDX_BITS-1:0] REG_COLOR_OFFSET = 3'd5;

  // Register reset values
  localparam logic signed [WORD_BITS-1:0] LEFT_RESET   = -32'sd33554432;
  localparam logic signed [WORD_BITS-1:0] TOP_RESET    = 32'sd20971520;
  localparam logic [STEP_BITS-1:0]        STEP_RESET   = 31'd2621440;
  localparam logic [ITER_BITS-1:0]        ITER_RESET   = 8'd20;
  localparam logic [OFFS_BITS-1:0]        OFFSET_RESET = 4'd0;

  // Palette
  localparam int PAL_SIZE = 15;
  localparam logic [OFFS_BITS-1:0] PAL_LAST = OFFS_BITS'(PAL_SIZE - 1);
  localparam logic [OFFS_BITS-1:0] PAL_WRAP = OFFS_BITS'(PAL_SIZE);

  // Queue between front and engine
  localparam int Q_DEPTH    = 2;
  localparam int Q_PTR_BITS = $clog2(Q_DEPTH);
  localparam int Q_CNT_BITS = $clog2(Q_DEPTH + 1);

  typedef struct packed {
    logic signed [WORD_BITS-1:0] cx;
    logic signed [WORD_BITS-1:0] cy;
  } point_t;

  typedef struct packed {
    logic not_empty;
    logic not_full;
  } q_status_t;

  typedef struct packed {
    logic [COLOR_BITS-1:0] red;
    logic [COLOR_BITS-1:0] green;
    logic [COLOR_BITS-1:0] blue;
  } rgb_t;

  typedef enum logic {
    ST_IDLE,
    ST_RUN
  } eng_state_t;

  function automatic logic signed [WORD_BITS-1:0] sat_sum(
    input logic signed [SUM_BITS-1:0] v
  );
    logic signed [WORD_BITS-1:0] r;
    if (v > SUM_MAX) begin
      r = WORD_MAX;
    end else if (v < SUM_MIN) begin
      r = WORD_MIN;
    end else begin
      r = v[WORD_BITS-1:0];
    end
    return r;
  endfunction

  function automatic logic signed [WORD_BITS-1:0] sat_coord(
    input logic signed [CSUM_BITS-1:0] v
  );
    logic signed [WORD_BITS-1:0] r;
    if (v > CSUM_MAX) begin
      r = WORD_MAX;
    end else if (v < CSUM_MIN) begin
      r = WORD_MIN;
    end else begin
      r = v[WORD_BITS-1:0];
    end
    return r;
  endfunction

  function automatic rgb_t pal_color(input logic [OFFS_BITS-1:0] idx);
    rgb_t c;
    case (idx)
      4'd0:    c = '{8'd0,   8'd0,   8'd255};
      4'd1:    c = '{8'd0,   8'd139, 8'd0};
      4'd2:    c = '{8'd0,   8'd255, 8'd255};
      4'd3:    c = '{8'd255, 8'd0,   8'd0};
      4'd4:    c = '{8'd255, 8'd0,   8'd255};
      4'd5:    c = '{8'd165, 8'd42,  8'd42};
      4'd6:    c = '{8'd240, 8'd240, 8'd240};
      4'd7:    c = '{8'd190, 8'd190, 8'd190};
      4'd8:    c = '{8'd173, 8'd216, 8'd230};
      4'd9:    c = '{8'd0,   8'd255, 8'd0};
      4'd10:   c = '{8'd224, 8'd255, 8'd255};
      4'd11:   c = '{8'd255, 8'd192, 8'd203};
      4'd12:   c = '{8'd139, 8'd0,   8'd139};
      4'd13:   c = '{8'd255, 8'd255, 8'd0};
      4'd14:   c = '{8'd255, 8'd255, 8'd255};
      default: c = '0;
    endcase
    return c;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/core/mep_front.sv =====
// ----------------------------------------------------------------------------
// mep_front - pixel intake
// Accepts a pixel, maps column and row to the point c and holds it until the
// queue takes it.
// ----------------------------------------------------------------------------
`default_nettype none

module mep_front import mep_pkg::*; (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        s_tvalid,
  output logic                             s_tready,
  input  wire logic [S_DATA_BITS-1:0]      s_tdata,   // [7:0] pixel_col, [15:8] pixel_row
  input  wire logic signed [WORD_BITS-1:0] left_real,
  input  wire logic signed [WORD_BITS-1:0] top_imag,
  input  wire logic [STEP_BITS-1:0]        step_real,
  input  wire logic [STEP_BITS-1:0]        step_imag,
  input  wire q_status_t                   q_stat,
  output logic                             push,
  output point_t                           push_data
);

  logic                         full;
  point_t                       point;
  logic [PIX_BITS-1:0]          col;
  logic [PIX_BITS-1:0]          row;
  logic [OFF_BITS-1:0]          re_off;
  logic [OFF_BITS-1:0]          im_off;
  logic signed [CSUM_BITS-1:0]  re_sum;
  logic signed [CSUM_BITS-1:0]  im_sum;

  assign col    = s_tdata[PIX_BITS-1:0];
  assign row    = s_tdata[2*PIX_BITS-1:PIX_BITS];
  assign re_off = col * step_real;
  assign im_off = row * step_imag;
  assign re_sum = CSUM_BITS'(left_real) + $signed(CSUM_BITS'(re_off));
  assign im_sum = CSUM_BITS'(top_imag) - $signed(CSUM_BITS'(im_off));

  assign push      = full && q_stat.not_full;
  assign push_data = point;
  assign s_tready  = !full || q_stat.not_full;

  always_ff @(posedge clk) begin
    if (rst) begin
      full <= 1'b0;
    end else if (s_tvalid && s_tready) begin
      full <= 1'b1;
    end else if (push) begin
      full <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      point.cx <= sat_coord(re_sum);
      point.cy <= sat_coord(im_sum);
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/mep_fifo.sv =====
// ----------------------------------------------------------------------------
// mep_fifo - point queue
// Short register queue that lets intake and iteration stall independently.
// ----------------------------------------------------------------------------
`default_nettype none

module mep_fifo import mep_pkg::*; (
  input  wire logic   clk,
  input  wire logic   rst,
  input  wire logic   push,
  input  wire point_t push_data,
  input  wire logic   pop,
  output point_t      pop_data,
  output q_status_t   stat
);

  point_t                entries [Q_DEPTH];
  logic [Q_PTR_BITS-1:0] wr_ptr;
  logic [Q_PTR_BITS-1:0] rd_ptr;
  logic [Q_CNT_BITS-1:0] count;

  assign stat.not_empty = (count != '0);
  assign stat.not_full  = (count != Q_CNT_BITS'(Q_DEPTH));
  assign pop_data       = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == Q_PTR_BITS'(Q_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == Q_PTR_BITS'(Q_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_data;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/mep_engine.sv =====
// ----------------------------------------------------------------------------
// mep_engine - escape-time iterator
// Runs z = z^2 + c one step per cycle, tests escape, colors the pixel and
// holds the result in the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module mep_engine import mep_pkg::*; (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire q_status_t              q_stat,
  input  wire point_t                 q_data,
  output logic                        pop,
  input  wire logic [ITER_BITS-1:0]   max_iter,
  input  wire logic [OFFS_BITS-1:0]   color_offset,
  output logic                        out_valid,
  input  wire logic                   out_ready,
  output logic [COUNT_BITS-1:0]       out_iter,
  output logic                        out_escaped,
  output rgb_t                        out_rgb
);

  eng_state_t                   state;
  eng_state_t                   state_next;
  logic signed [WORD_BITS-1:0]  cx;
  logic signed [WORD_BITS-1:0]  cy;
  logic signed [WORD_BITS-1:0]  x;
  logic signed [WORD_BITS-1:0]  y;
  logic [COUNT_BITS-1:0]        k;
  logic [OFFS_BITS-1:0]         cidx;

  logic signed [MAG_BITS-1:0]   xm;
  logic signed [MAG_BITS-1:0]   ym;
  logic signed [PROD_BITS-1:0]  pxx;
  logic signed [PROD_BITS-1:0]  pyy;
  logic signed [PROD_BITS-1:0]  pxy;
  logic signed [TERM_BITS-1:0]  xsq;
  logic signed [TERM_BITS-1:0]  ysq;
  logic signed [TERM_BITS-1:0]  twoxy;
  logic signed [WORD_BITS-1:0]  nx;
  logic signed [WORD_BITS-1:0]  ny;
  logic                         out_range;
  logic                         mag_big;
  logic                         escape;
  logic                         limit;
  logic                         finish;
  logic                         out_free;
  logic                         step;
  logic                         load_out;

  // Operands beyond +-2.0 escape before their products are used
  assign xm    = x[MAG_BITS-1:0];
  assign ym    = y[MAG_BITS-1:0];
  assign pxx   = xm * xm;
  assign pyy   = ym * ym;
  assign pxy   = xm * ym;
  assign xsq   = pxx[FRAC_BITS +: TERM_BITS];
  assign ysq   = pyy[FRAC_BITS +: TERM_BITS];
  assign twoxy = pxy[FRAC_BITS-1 +: TERM_BITS];

  assign nx = sat_sum(SUM_BITS'(xsq) - SUM_BITS'(ysq) + SUM_BITS'(cx));
  assign ny = sat_sum(SUM_BITS'(twoxy) + SUM_BITS'(cy));

  assign out_range = (x > BOUND_POS) || (x < BOUND_NEG) ||
                     (y > BOUND_POS) || (y < BOUND_NEG);
  assign mag_big   = (xsq + ysq) > FOUR_TERM;
  // z is still zero before the first step
  assign escape    = (k != '0) && (out_range || mag_big);
  assign limit     = k > COUNT_BITS'(max_iter);
  assign finish    = escape || limit;
  assign out_free  = !out_valid || out_ready;

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (q_stat.not_empty) begin
          state_next = ST_RUN;
        end
      end
      ST_RUN: begin
        if (finish && out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    pop      = 1'b0;
    step     = 1'b0;
    load_out = 1'b0;
    case (state)
      ST_IDLE: begin
        pop = q_stat.not_empty;
      end
      ST_RUN: begin
        step     = !finish;
        load_out = finish && out_free;
      end
      default: begin
        pop = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (load_out) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      cx   <= q_data.cx;
      cy   <= q_data.cy;
      x    <= '0;
      y    <= '0;
      k    <= '0;
      cidx <= (color_offset == PAL_WRAP) ? '0 : color_offset;
    end else if (step) begin
      x    <= nx;
      y    <= ny;
      k    <= k + 1'b1;
      cidx <= (cidx == PAL_LAST) ? '0 : cidx + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_iter    <= k;
      out_escaped <= !limit;
      out_rgb     <= limit ? '0 : pal_color(cidx);
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/mandelbrot_escape_pixel.sv =====
// ----------------------------------------------------------------------------
// mandelbrot_escape_pixel - Mandelbrot escape-time pixel
// Configuration registers, intake, point queue and iteration engine.
// ----------------------------------------------------------------------------
// Each accepted pixel (column, row) is mapped to c = (left_real + col*step_real,
// top_imag - row*step_imag) in Q8.24 and iterated one step per clock by a
// single datapath of three 27x27 multipliers. A pixel occupies the engine
// until it escapes or its count passes max_iter, and the engine takes no new
// pixel before its result is loaded; that loop sets the throughput. Intake
// registers the point c, and a two-entry queue lets up to three further
// pixels be taken while the engine works. The result (count, escaped flag and
// palette color, black when not escaped) sits in an output register until
// taken. Write configuration only while the block is idle.
`default_nettype none

module mandelbrot_escape_pixel import mep_pkg::*; (
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire logic                     s_tvalid,
  output logic                          s_tready,
  input  wire logic [S_DATA_BITS-1:0]   s_tdata,  // [7:0] pixel_col, [15:8] pixel_row
  output logic                          m_tvalid,
  input  wire logic                     m_tready,
  // [8:0] iterations, [16:9] red, [24:17] green, [32:25] blue, [39:33] zero
  output logic [M_DATA_BITS-1:0]        m_tdata,
  output logic                          m_tuser,  // [0] escaped
  input  wire logic                     cfg_valid,
  output logic                          cfg_ready,
  input  wire logic [CFG_IDX_BITS-1:0]  cfg_index,
  input  wire logic [CFG_DATA_BITS-1:0] cfg_data
);

  logic signed [WORD_BITS-1:0] left_real;
  logic signed [WORD_BITS-1:0] top_imag;
  logic [STEP_BITS-1:0]        step_real;
  logic [STEP_BITS-1:0]        step_imag;
  logic [ITER_BITS-1:0]        max_iter;
  logic [OFFS_BITS-1:0]        color_offset;

  q_status_t                   q_stat;
  logic                        push;
  point_t                      push_data;
  logic                        pop;
  point_t                      pop_data;
  logic [COUNT_BITS-1:0]       out_iter;
  logic                        out_escaped;
  rgb_t                        out_rgb;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      left_real    <= LEFT_RESET;
      top_imag     <= TOP_RESET;
      step_real    <= STEP_RESET;
      step_imag    <= STEP_RESET;
      max_iter     <= ITER_RESET;
      color_offset <= OFFSET_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_LEFT_REAL:    left_real    <= cfg_data[WORD_BITS-1:0];
        REG_TOP_IMAG:     top_imag     <= cfg_data[WORD_BITS-1:0];
        REG_STEP_REAL:    step_real    <= cfg_data[STEP_BITS-1:0];
        REG_STEP_IMAG:    step_imag    <= cfg_data[STEP_BITS-1:0];
        REG_MAX_ITER:     max_iter     <= cfg_data[ITER_BITS-1:0];
        REG_COLOR_OFFSET: color_offset <= cfg_data[OFFS_BITS-1:0];
        default: begin
          // drop writes to unused indexes
        end
      endcase
    end
  end

  mep_front u_front (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .left_real (left_real),
    .top_imag  (top_imag),
    .step_real (step_real),
    .step_imag (step_imag),
    .q_stat    (q_stat),
    .push      (push),
    .push_data (push_data)
  );

  mep_fifo u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .pop_data  (pop_data),
    .stat      (q_stat)
  );

  mep_engine u_engine (
    .clk          (clk),
    .rst          (rst),
    .q_stat       (q_stat),
    .q_data       (pop_data),
    .pop          (pop),
    .max_iter     (max_iter),
    .color_offset (color_offset),
    .out_valid    (m_tvalid),
    .out_ready    (m_tready),
    .out_iter     (out_iter),
    .out_escaped  (out_escaped),
    .out_rgb      (out_rgb)
  );

  assign m_tdata = {(M_DATA_BITS - M_DATA_RAW)'(0),
                    out_rgb.blue, out_rgb.green, out_rgb.red, out_iter};
  assign m_tuser = out_escaped;

endmodule

`default_nettype wire

// ===== verif/mandelbrot_escape_pixel_tb.sv =====
// ----------------------------------------------------------------------------
// mandelbrot_escape_pixel_tb - self-checking bench for the escape-time pixel
// Streams pixel coordinates through the block under several view windows,
// iteration limits and palette rotations, predicts each pixel's count, flag
// and color in Q8.24 fixed point, and compares every returned transfer in
// order. Both stream sides idle at random; one long output stall fills the
// block up.
// ----------------------------------------------------------------------------

module mandelbrot_escape_pixel_tb import mep_pkg::*; ();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int          RESET_CYCLES   = 7;
  localparam int          PHASES         = 14;
  localparam int          PHASE_PIXELS   = 50;
  localparam int          HOLD_CYCLES    = 1200;
  localparam int          SETTLE_CYCLES  = 300;
  localparam int          WATCHDOG_LIMIT = 10000;
  localparam int          UNIT           = 1 << FRAC_BITS;
  localparam longint      SAT_HI         = (longint'(1) << (WORD_BITS - 1)) - 1;
  localparam longint      SAT_LO         = -SAT_HI - 1;
  localparam logic [63:0] ESCAPE_RADIUS  = 64'd2 << FRAC_BITS;
  localparam longint      ESCAPE_NORM    = longint'(4) << FRAC_BITS;
  localparam logic [23:0] BLACK          = 24'h000000;

  // {red, green, blue} per entry, entry 0 in the lowest bits
  localparam logic [PAL_SIZE*24-1:0] PALETTE = {
    24'hFFFFFF, 24'hFFFF00, 24'h8B008B, 24'hFFC0CB, 24'hE0FFFF,
    24'h00FF00, 24'hADD8E6, 24'hBEBEBE, 24'hF0F0F0, 24'hA52A2A,
    24'hFF00FF, 24'hFF0000, 24'h00FFFF, 24'h008B00, 24'h0000FF
  };

  typedef struct packed {
    logic [COUNT_BITS-1:0] iterations;
    logic                  escaped;
    logic [7:0]            red;
    logic [7:0]            green;
    logic [7:0]            blue;
  } pixel_result_t;

  typedef struct {
    bit                      is_write;
    logic [CFG_IDX_BITS-1:0] reg_idx;
    logic [31:0]             value;
    logic [7:0]              col;
    logic [7:0]              row;
    bit                      known;
    pixel_result_t           result;
  } sweep_op_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic                     s_tvalid;
  logic                     s_tready;
  logic [S_DATA_BITS-1:0]   s_tdata;
  logic                     m_tvalid;
  logic                     m_tready;
  logic [M_DATA_BITS-1:0]   m_tdata;
  logic                     m_tuser;
  logic                     cfg_valid;
  logic                     cfg_ready;
  logic [CFG_IDX_BITS-1:0]  cfg_index;
  logic [CFG_DATA_BITS-1:0] cfg_data;

  // travels alongside s_tdata: a result typed into the sweep table
  logic          tag_known;
  pixel_result_t tag_result;

  // register shadow
  logic signed [WORD_BITS-1:0] view_left;
  logic signed [WORD_BITS-1:0] view_top;
  logic [STEP_BITS-1:0]        view_step_re;
  logic [STEP_BITS-1:0]        view_step_im;
  logic [ITER_BITS-1:0]        iter_limit;
  logic [OFFS_BITS-1:0]        hue_shift;

  pixel_result_t pending_pixels[$];
  sweep_op_t     directed_ops[$];
  int unsigned   pixels_sent;
  int unsigned   pixels_returned;
  int unsigned   mismatch_count;
  int unsigned   quiet_cycles;
  bit            sender_steady;
  bit            sink_steady;
  bit            long_hold_req;
  bit            long_hold_done;

  mandelbrot_escape_pixel uut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),    // [7:0] pixel_col, [15:8] pixel_row
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),    // [8:0] iterations, [16:9] red, [24:17] green, [32:25] blue
    .m_tuser   (m_tuser),    // [0] escaped
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #6 clk = ~clk;

  function automatic longint clamp_word(input longint v);
    if (v > SAT_HI) return SAT_HI;
    if (v < SAT_LO) return SAT_LO;
    return v;
  endfunction

  function automatic logic [63:0] magnitude(input longint v);
    return (v < 0) ? 64'(-v) : 64'(v);
  endfunction

  function automatic pixel_result_t escape_time(input logic [7:0] col, input logic [7:0] row);
    longint        cx, cy, x, y, xsq, ysq, twoxy, nx;
    logic [63:0]   ax, ay, prod;
    int unsigned   k;
    bit            left_disk;
    logic [23:0]   rgb;
    pixel_result_t r;
    cx = clamp_word(longint'(view_left) + longint'(col) * longint'(view_step_re));
    cy = clamp_word(longint'(view_top) - longint'(row) * longint'(view_step_im));
    x = 0;
    y = 0;
    xsq = 0;
    ysq = 0;
    k = 0;
    left_disk = 1'b0;
    while (!left_disk && k <= iter_limit) begin
      // 2xy rounds toward minus infinity, so a negative product with lost bits drops by one
      ax = magnitude(x);
      ay = magnitude(y);
      prod = ax * ay;
      twoxy = longint'(prod >> (FRAC_BITS - 1));
      if ((x < 0) != (y < 0)) begin
        if (prod[FRAC_BITS-2:0] != '0) twoxy = twoxy + 1;
        twoxy = -twoxy;
      end
      nx = clamp_word(xsq - ysq + cx);
      y = clamp_word(twoxy + cy);
      x = nx;
      k++;
      ax = magnitude(x);
      ay = magnitude(y);
      if (ax > ESCAPE_RADIUS || ay > ESCAPE_RADIUS) begin
        left_disk = 1'b1;
      end else begin
        xsq = longint'((ax * ax) >> FRAC_BITS);
        ysq = longint'((ay * ay) >> FRAC_BITS);
        if (xsq + ysq > ESCAPE_NORM) left_disk = 1'b1;
      end
    end
    r.iterations = k[COUNT_BITS-1:0];
    r.escaped = (k <= iter_limit);
    rgb = r.escaped ? PALETTE[((k + hue_shift) % PAL_SIZE) * 24 +: 24] : BLACK;
    r.red = rgb[23:16];
    r.green = rgb[15:8];
    r.blue = rgb[7:0];
    return r;
  endfunction

  function automatic sweep_op_t reg_op(input logic [CFG_IDX_BITS-1:0] idx,
                                       input logic [31:0] value);
    sweep_op_t op;
    op = '{default: '0};
    op.is_write = 1'b1;
    op.reg_idx = idx;
    op.value = value;
    return op;
  endfunction

  function automatic sweep_op_t pixel_op(input logic [7:0] col, input logic [7:0] row);
    sweep_op_t op;
    op = '{default: '0};
    op.col = col;
    op.row = row;
    return op;
  endfunction

  function automatic sweep_op_t known_op(input logic [7:0] col, input logic [7:0] row,
                                         input int unsigned iters, input bit esc,
                                         input logic [23:0] rgb);
    sweep_op_t op;
    op = pixel_op(col, row);
    op.known = 1'b1;
    op.result.iterations = iters[COUNT_BITS-1:0];
    op.result.escaped = esc;
    op.result.red = rgb[23:16];
    op.result.green = rgb[15:8];
    op.result.blue = rgb[7:0];
    return op;
  endfunction

  function automatic int unsigned pick_span();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 75) return $urandom_range(1, 3);
    if (roll < 95) return $urandom_range(4, 16);
    return $urandom_range(17, 60);
  endfunction

  function automatic int unsigned pick_gap();
    if (sender_steady || $urandom_range(0, 99) < 45) return 0;
    return pick_span();
  endfunction

  task automatic check_field(input string field, input int unsigned want,
                             input int unsigned got);
    if (want != got) begin
      $display("%0t ns: %s mismatch, expected %0d, got %0d", $time, field, want, got);
      mismatch_count++;
    end
  endtask

  // drop both valids and hold until every accepted pixel has come back
  task automatic wait_drained();
    s_tvalid <= 1'b0;
    cfg_valid <= 1'b0;
    do @(posedge clk); while (pixels_returned != pixels_sent);
  endtask

  task automatic write_reg(input logic [CFG_IDX_BITS-1:0] idx, input logic [31:0] value);
    wait_drained();
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      REG_LEFT_REAL:    view_left = value;
      REG_TOP_IMAG:     view_top = value;
      REG_STEP_REAL:    view_step_re = value[STEP_BITS-1:0];
      REG_STEP_IMAG:    view_step_im = value[STEP_BITS-1:0];
      REG_MAX_ITER:     iter_limit = value[ITER_BITS-1:0];
      REG_COLOR_OFFSET: hue_shift = value[OFFS_BITS-1:0];
      default: ;
    endcase
  endtask

  task automatic send_pixel(input logic [7:0] col, input logic [7:0] row,
                            input bit known, input pixel_result_t result);
    int unsigned gap;
    gap = pick_gap();
    cfg_valid <= 1'b0;
    if (gap != 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= {row, col};
    tag_known <= known;
    tag_result <= result;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    pixels_sent++;
  endtask

  task automatic random_view();
    int unsigned shape;
    logic [31:0] re0, im0, sre, sim, limit;
    shape = $urandom_range(0, 9);
    if (shape == 0) begin
      re0 = $urandom;
      im0 = $urandom;
      sre = $urandom;
      sim = $urandom;
    end else if (shape == 1) begin
      re0 = $urandom_range(0, 1) ? WORD_MAX : WORD_MIN;
      im0 = $urandom_range(0, 1) ? WORD_MAX : WORD_MIN;
      sre = $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h0;
      sim = $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h0;
    end else begin
      // a window near the set, from a wide view down to a deep zoom
      re0 = 32'(-(5 * UNIT / 2) + int'($urandom_range(0, 2 * UNIT)));
      im0 = 32'(-(UNIT / 2) + int'($urandom_range(0, 2 * UNIT)));
      sre = $urandom_range(1 << 12, 1 << 19);
      sim = $urandom_range(1 << 12, 1 << 19);
    end
    case ($urandom_range(0, 9))
      0:       limit = 0;
      1:       limit = 255;
      2:       limit = 1;
      default: limit = $urandom_range(2, 48);
    endcase
    write_reg(REG_LEFT_REAL, re0);
    write_reg(REG_TOP_IMAG, im0);
    write_reg(REG_STEP_REAL, sre);
    write_reg(REG_STEP_IMAG, sim);
    write_reg(REG_MAX_ITER, limit);
    write_reg(REG_COLOR_OFFSET, $urandom_range(0, 15));
  endtask

  // result checking and prediction on each accepted transfer
  always @(posedge clk) begin : pixel_scoreboard
    pixel_result_t want;
    if (!rst) begin
      if (m_tvalid && m_tready) begin
        pixels_returned++;
        if (pending_pixels.size() == 0) begin
          $display("%0t ns: result with nothing expected, got iterations %0d",
                   $time, m_tdata[8:0]);
          mismatch_count++;
        end else begin
          want = pending_pixels.pop_front();
          check_field("iterations", want.iterations, m_tdata[8:0]);
          check_field("escaped", want.escaped, m_tuser);
          check_field("red", want.red, m_tdata[16:9]);
          check_field("green", want.green, m_tdata[24:17]);
          check_field("blue", want.blue, m_tdata[32:25]);
        end
      end
      if (s_tvalid && s_tready) begin
        pending_pixels.push_back(tag_known ? tag_result :
                                 escape_time(s_tdata[7:0], s_tdata[15:8]));
      end
    end
  end

  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t ns: no transfer for %0d cycles", $time, quiet_cycles);
      $display("FAIL");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin : result_sink
    int unsigned span;
    m_tready = 1'b0;
    @(posedge clk);
    forever begin
      if (long_hold_req && !long_hold_done) begin
        // stall long enough for the queue to fill and block the intake
        m_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        long_hold_done = 1'b1;
      end else if (sink_steady) begin
        m_tready <= 1'b1;
        @(posedge clk);
      end else begin
        m_tready <= ($urandom_range(0, 99) < 65);
        span = pick_span();
        repeat (span) @(posedge clk);
      end
    end
  end

  initial begin : pixel_source
    s_tvalid = 1'b0;
    s_tdata = '0;
    tag_known = 1'b0;
    tag_result = '0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    quiet_cycles = 0;
    pixels_sent = 0;
    pixels_returned = 0;
    mismatch_count = 0;
    sender_steady = 1'b0;
    sink_steady = 1'b0;
    long_hold_req = 1'b0;
    long_hold_done = 1'b0;
    view_left = LEFT_RESET;
    view_top = TOP_RESET;
    view_step_re = STEP_RESET;
    view_step_im = STEP_RESET;
    iter_limit = ITER_RESET;
    hue_shift = OFFSET_RESET;

    // reset view: the corners leave the radius-two disk on the first step
    directed_ops.push_back(known_op(0, 0, 1, 1'b1, 24'h008B00));
    directed_ops.push_back(known_op(255, 255, 1, 1'b1, 24'h008B00));
    directed_ops.push_back(pixel_op(0, 255));
    directed_ops.push_back(pixel_op(255, 0));
    directed_ops.push_back(pixel_op(13, 8));
    directed_ops.push_back(pixel_op(3, 6));
    directed_ops.push_back(pixel_op(5, 2));
    directed_ops.push_back(pixel_op(10, 15));
    // zero limit: one pass runs, nothing counts as escaped
    directed_ops.push_back(reg_op(REG_MAX_ITER, 0));
    directed_ops.push_back(known_op(0, 0, 1, 1'b0, BLACK));
    directed_ops.push_back(known_op(13, 8, 1, 1'b0, BLACK));
    directed_ops.push_back(reg_op(REG_MAX_ITER, 255));
    directed_ops.push_back(reg_op(REG_COLOR_OFFSET, 14));
    directed_ops.push_back(known_op(0, 0, 1, 1'b1, 24'h0000FF));
    directed_ops.push_back(pixel_op(13, 8));
    // rotation of fifteen wraps back onto the palette
    directed_ops.push_back(reg_op(REG_COLOR_OFFSET, 15));
    directed_ops.push_back(known_op(0, 0, 1, 1'b1, 24'h008B00));
    directed_ops.push_back(pixel_op(12, 8));
    // coordinates pushed past the word range saturate
    directed_ops.push_back(reg_op(REG_LEFT_REAL, WORD_MAX));
    directed_ops.push_back(reg_op(REG_TOP_IMAG, WORD_MIN));
    directed_ops.push_back(reg_op(REG_STEP_REAL, 32'h7FFF_FFFF));
    directed_ops.push_back(reg_op(REG_STEP_IMAG, 32'h7FFF_FFFF));
    directed_ops.push_back(known_op(255, 255, 1, 1'b1, 24'h008B00));
    directed_ops.push_back(known_op(0, 0, 1, 1'b1, 24'h008B00));
    directed_ops.push_back(reg_op(REG_LEFT_REAL, WORD_MIN));
    directed_ops.push_back(reg_op(REG_TOP_IMAG, WORD_MAX));
    directed_ops.push_back(known_op(255, 0, 1, 1'b1, 24'h008B00));
    directed_ops.push_back(known_op(0, 255, 1, 1'b1, 24'h008B00));
    directed_ops.push_back(pixel_op(128, 128));
    // c at the origin never escapes
    directed_ops.push_back(reg_op(REG_LEFT_REAL, 0));
    directed_ops.push_back(reg_op(REG_TOP_IMAG, 0));
    directed_ops.push_back(reg_op(REG_STEP_REAL, 0));
    directed_ops.push_back(reg_op(REG_STEP_IMAG, 0));
    directed_ops.push_back(reg_op(REG_MAX_ITER, 1));
    directed_ops.push_back(reg_op(REG_COLOR_OFFSET, 0));
    directed_ops.push_back(known_op(255, 255, 2, 1'b0, BLACK));
    directed_ops.push_back(known_op(170, 85, 2, 1'b0, BLACK));
    directed_ops.push_back(reg_op(REG_MAX_ITER, 255));
    directed_ops.push_back(known_op(0, 0, 256, 1'b0, BLACK));

    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;

    foreach (directed_ops[i]) begin
      if (directed_ops[i].is_write) begin
        write_reg(directed_ops[i].reg_idx, directed_ops[i].value);
      end else begin
        send_pixel(directed_ops[i].col, directed_ops[i].row,
                   directed_ops[i].known, directed_ops[i].result);
      end
    end

    for (int phase = 0; phase < PHASES; phase++) begin
      random_view();
      sender_steady = (phase == 2) || (phase == 5);
      sink_steady = (phase == 5);
      if (phase == 2) long_hold_req = 1'b1;
      for (int n = 0; n < PHASE_PIXELS; n++) begin
        if (phase == 7 && n == PHASE_PIXELS / 2) wait_drained();
        send_pixel($urandom_range(0, 255), $urandom_range(0, 255), 1'b0, '0);
      end
    end

    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (pending_pixels.size() != 0) begin
      $display("%0t ns: %0d expected results never arrived", $time, pending_pixels.size());
      mismatch_count++;
    end
    if (mismatch_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
